/* sv/urxif_pkg.sv */
// Shared types and constants for the UART receiver with idle-line framing.
package urxif_pkg;

    // Bytes that one frame can hold before further bytes are dropped
    localparam int FRAME_CAPACITY = 256;
    localparam int FRAME_CNT_W    = $clog2(FRAME_CAPACITY + 1);
    localparam int FRAME_LEN_W    = 9;

    localparam int TPB_W        = 16;
    localparam int IDLE_CHARS_W = 8;
    localparam int CHAR_BITS    = 10;
    localparam int IDLE_MUL_W   = 12;   // idle_chars * 10 fits 12 bits
    localparam int THRESH_W     = TPB_W + IDLE_MUL_W;
    localparam int IDLE_CNT_W   = THRESH_W;   // saturating; its top value lies above any threshold

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    // Register byte addresses
    localparam logic [APB_ADDR_W-1:0] ADDR_ENABLE     = 4'h0;
    localparam logic [APB_ADDR_W-1:0] ADDR_TICKS_PER_BIT = 4'h4;
    localparam logic [APB_ADDR_W-1:0] ADDR_IDLE_CHARS = 4'h8;

    localparam logic [TPB_W-1:0]        TPB_RESET        = 16'd625;
    localparam logic [IDLE_CHARS_W-1:0] IDLE_CHARS_RESET = 8'd20;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_START = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_STOP  = 4'b1000
    } rx_phase_t;

    typedef struct packed {
        logic [FRAME_LEN_W-1:0] frame_length;
        logic                   frame_ready;
        logic                   byte_stored;
        logic [7:0]             byte_index;
        logic [7:0]             rx_data;
        logic                   byte_valid;
    } rx_result_t;

endpackage

/* sv/uart_rx_with_idle_framing_core.sv */
// UART 8N1 receiver with idle-line framing, APB config and stream ports.
//
// One input word per clock, while s_tready is high, is one oversampling tick of
// the RX line; every word yields exactly one registered result word. Throughput
// is one word per cycle while m_tready is high: the receiver state updates in a
// single pass of logic from input to output register, and the two-entry output
// buffer keeps s_tready high as m_tready drops. A falling edge starts a
// character, the start bit is checked half a bit later, data bits are sampled
// LSB first at bit midpoints and the stop bit is not checked. Bytes carry their
// index in the current frame; bytes beyond the frame capacity are flagged as
// dropped. frame_ready rises after idle_chars character times of silence once
// a byte is stored, and clear_frame resets the frame. Clearing enable returns
// the receiver to its reset state and makes all result fields zero.
module uart_rx_with_idle_framing_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // stream input, tdata: [0] rx_line, [1] clear_frame, [7:2] zero
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [urxif_pkg::S_TDATA_W-1:0]      s_tdata,
    // stream output, tdata: [0] byte_valid, [8:1] rx_data, [16:9] byte_index,
    // [17] byte_stored, [18] frame_ready, [27:19] frame_length, [31:28] zero
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [urxif_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [urxif_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [urxif_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [urxif_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);
    import urxif_pkg::*;

    // configuration registers
    logic                    enable_reg;
    logic [TPB_W-1:0]        tpb_reg;
    logic [IDLE_CHARS_W-1:0] idle_chars_reg;

    // receiver state
    logic                   prev_line_reg,   prev_line_next;
    rx_phase_t              phase_reg,       phase_next;
    logic [TPB_W-1:0]       tick_reg,        tick_next;
    logic [3:0]             bit_cnt_reg,     bit_cnt_next;
    logic [7:0]             shift_reg,       shift_next;
    logic [FRAME_CNT_W-1:0] frame_cnt_reg,   frame_cnt_next;
    logic                   ready_reg,       ready_next;
    logic [IDLE_CNT_W-1:0]  idle_reg,        idle_next;

    // output buffer
    logic       out_valid_reg, skid_valid_reg;
    rx_result_t out_reg, skid_reg;
    rx_result_t result;

    logic rx_line, clear_frame, accept, apb_write;
    logic [TPB_W-1:0]      cpb, half, tick_inc;
    logic [IDLE_MUL_W-1:0] idle_mul;
    logic [THRESH_W-1:0]   threshold;
    logic [IDLE_CNT_W-1:0] idle_inc;

    assign rx_line     = s_tdata[0];
    assign clear_frame = s_tdata[1];
    assign s_tready    = ~skid_valid_reg;
    assign accept      = s_tvalid & s_tready;

    assign pready    = 1'b1;
    assign apb_write = psel & penable & pwrite;

    always_comb begin
        unique case (paddr)
            ADDR_ENABLE:        prdata = APB_DATA_W'(enable_reg);
            ADDR_TICKS_PER_BIT: prdata = APB_DATA_W'(tpb_reg);
            ADDR_IDLE_CHARS:    prdata = APB_DATA_W'(idle_chars_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b0;
            tpb_reg        <= TPB_RESET;
            idle_chars_reg <= IDLE_CHARS_RESET;
        end else if (apb_write) begin
            unique case (paddr)
                ADDR_ENABLE:        enable_reg     <= pwdata[0];
                ADDR_TICKS_PER_BIT: tpb_reg        <= pwdata[TPB_W-1:0];
                ADDR_IDLE_CHARS:    idle_chars_reg <= pwdata[IDLE_CHARS_W-1:0];
                default: ;
            endcase
        end
    end

    // bit timing and idle threshold
    always_comb begin
        cpb = (tpb_reg == '0) ? TPB_W'(1) : tpb_reg;
        half = cpb >> 1;
        if (half == '0) begin
            half = TPB_W'(1);
        end
        idle_mul  = IDLE_MUL_W'(idle_chars_reg) * IDLE_MUL_W'(CHAR_BITS);
        threshold = THRESH_W'(cpb) * THRESH_W'(idle_mul);
        tick_inc  = tick_reg + TPB_W'(1);
        idle_inc  = (&idle_reg) ? idle_reg : idle_reg + IDLE_CNT_W'(1);
    end

    always_comb begin
        prev_line_next = prev_line_reg;
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        frame_cnt_next = frame_cnt_reg;
        ready_next     = ready_reg;
        idle_next      = idle_reg;
        result         = '0;

        if (!enable_reg) begin
            prev_line_next = 1'b1;
            phase_next     = PH_IDLE;
            tick_next      = '0;
            bit_cnt_next   = '0;
            shift_next     = '0;
            frame_cnt_next = '0;
            ready_next     = 1'b0;
            idle_next      = '0;
        end else begin
            // clear acts first, so a byte on the same tick opens the new frame
            if (clear_frame) begin
                frame_cnt_next = '0;
                ready_next     = 1'b0;
            end
            idle_next = idle_inc;

            unique case (phase_reg)
                PH_IDLE: begin
                    if (prev_line_reg && !rx_line) begin
                        phase_next = PH_START;
                        tick_next  = '0;
                    end else if (frame_cnt_next != '0 &&
                                 IDLE_CNT_W'(idle_inc) >= IDLE_CNT_W'(threshold)) begin
                        ready_next = 1'b1;
                    end
                    prev_line_next = rx_line;
                end
                PH_START: begin
                    tick_next = tick_inc;
                    if (tick_inc >= half) begin
                        tick_next = '0;
                        if (rx_line) begin
                            phase_next = PH_IDLE;   // glitch
                        end else begin
                            phase_next   = PH_DATA;
                            bit_cnt_next = '0;
                            shift_next   = '0;
                        end
                    end
                end
                PH_DATA: begin
                    tick_next = tick_inc;
                    if (tick_inc >= cpb) begin
                        tick_next = '0;
                        if (rx_line) begin
                            shift_next[bit_cnt_reg[2:0]] = 1'b1;
                        end
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        if (bit_cnt_next >= 4'd8) begin
                            phase_next = PH_STOP;
                        end
                    end
                end
                PH_STOP: begin
                    tick_next = tick_inc;
                    if (tick_inc >= cpb) begin
                        tick_next         = '0;
                        bit_cnt_next      = '0;
                        phase_next        = PH_IDLE;
                        prev_line_next    = rx_line;
                        result.byte_valid = 1'b1;
                        result.rx_data    = shift_reg;
                        if (frame_cnt_next < FRAME_CNT_W'(FRAME_CAPACITY)) begin
                            result.byte_stored = 1'b1;
                            result.byte_index  = 8'(frame_cnt_next);
                            frame_cnt_next     = frame_cnt_next + FRAME_CNT_W'(1);
                        end
                        idle_next = '0;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            endcase
            result.frame_ready  = ready_next;
            result.frame_length = FRAME_LEN_W'(frame_cnt_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_line_reg <= 1'b1;
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            frame_cnt_reg <= '0;
            ready_reg     <= 1'b0;
            idle_reg      <= '0;
        end else if (accept) begin
            prev_line_reg <= prev_line_next;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            frame_cnt_reg <= frame_cnt_next;
            ready_reg     <= ready_next;
            idle_reg      <= idle_next;
        end
    end

    // output register with a skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end else if (accept) begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench for the UART receiver core: line-tick stimulus, predicted result words and APB setup.
module tb;
    import urxif_pkg::*;

    localparam int LIMIT_CYCLES = 5_000_000;
    localparam int MAX_REPORTS  = 200;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_TICKS  = 140;
    localparam int RUN_BYTES    = 6;

    typedef struct packed {
        logic clr;
        logic line;
    } line_tick_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    uart_rx_with_idle_framing_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // register copies
    logic                    cfg_enable     = 1'b0;
    logic [TPB_W-1:0]        cfg_tpb        = TPB_RESET;
    logic [IDLE_CHARS_W-1:0] cfg_idle_chars = IDLE_CHARS_RESET;

    // receiver state as the core should hold it
    logic                   rcv_prev  = 1'b1;
    rx_phase_t              rcv_phase = PH_IDLE;
    logic [TPB_W-1:0]       rcv_ticks = '0;
    logic [3:0]             rcv_bits  = '0;
    logic [7:0]             rcv_shift = '0;
    logic [FRAME_CNT_W-1:0] rcv_count = '0;
    logic                   rcv_ready = 1'b0;
    logic [31:0]            rcv_idle  = '0;

    line_tick_t line_ticks[$];
    rx_result_t rx_words_due[$];

    int fault_count     = 0;
    int cycle_count     = 0;
    int send_gap        = 0;
    int sink_wait       = 0;
    int clear_permille  = 0;
    int phase_ticks     = 0;
    bit src_calm        = 1'b0;
    bit sink_calm       = 1'b0;

    int rand_tpb[RAND_PHASES]  = '{4, 5, 3, 1, 0, 2, 7, 6};
    int rand_idle[RAND_PHASES] = '{1, 2, 0, 1, 3, 1, 2, 1};

    function automatic void note_mismatch(input string field, input int unsigned want_v,
                                          input int unsigned got_v);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%0t: %s expected %0h actual %0h", $time, field, want_v, got_v);
    endfunction

    function automatic int pick_gap(input bit calm);
        int unsigned roll = $urandom_range(99);
        if (calm || roll < 65)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        if (roll < 98)
            return $urandom_range(12, 4);
        return $urandom_range(50, 20);
    endfunction

    task automatic predict_rx_word(input line_tick_t t, output rx_result_t r);
        logic [TPB_W-1:0] cpb;
        logic [TPB_W-1:0] half;
        logic [31:0]      threshold;
        r = '0;
        if (!cfg_enable) begin
            rcv_prev  = 1'b1;
            rcv_phase = PH_IDLE;
            rcv_ticks = '0;
            rcv_bits  = '0;
            rcv_shift = '0;
            rcv_count = '0;
            rcv_ready = 1'b0;
            rcv_idle  = '0;
            return;
        end
        cpb = (cfg_tpb == '0) ? TPB_W'(1) : cfg_tpb;
        half = cpb >> 1;
        if (half == '0)
            half = TPB_W'(1);
        threshold = 32'(cpb) * 32'(CHAR_BITS) * 32'(cfg_idle_chars);

        // clear goes first, so a byte on the same tick opens the new frame
        if (t.clr) begin
            rcv_count = '0;
            rcv_ready = 1'b0;
        end
        if (rcv_idle != '1)
            rcv_idle++;

        case (rcv_phase)
            PH_IDLE: begin
                if (rcv_prev && !t.line) begin
                    rcv_phase = PH_START;
                    rcv_ticks = '0;
                end else if (rcv_count != '0 && rcv_idle >= threshold) begin
                    rcv_ready = 1'b1;
                end
                rcv_prev = t.line;
            end
            PH_START: begin
                rcv_ticks++;
                if (rcv_ticks >= half) begin
                    rcv_ticks = '0;
                    if (t.line) begin
                        rcv_phase = PH_IDLE;
                    end else begin
                        rcv_phase = PH_DATA;
                        rcv_bits  = '0;
                        rcv_shift = '0;
                    end
                end
            end
            PH_DATA: begin
                rcv_ticks++;
                if (rcv_ticks >= cpb) begin
                    rcv_ticks = '0;
                    if (t.line)
                        rcv_shift[rcv_bits[2:0]] = 1'b1;
                    rcv_bits++;
                    if (rcv_bits >= 4'd8)
                        rcv_phase = PH_STOP;
                end
            end
            default: begin
                rcv_ticks++;
                if (rcv_ticks >= cpb) begin
                    // stop bit is not checked; edge detector reloads from the line
                    rcv_ticks    = '0;
                    rcv_bits     = '0;
                    rcv_phase    = PH_IDLE;
                    rcv_prev     = t.line;
                    r.byte_valid = 1'b1;
                    r.rx_data    = rcv_shift;
                    if (rcv_count < FRAME_CAPACITY) begin
                        r.byte_stored = 1'b1;
                        r.byte_index  = rcv_count[7:0];
                        rcv_count++;
                    end
                    rcv_idle = '0;
                end
            end
        endcase
        r.frame_ready  = rcv_ready;
        r.frame_length = FRAME_LEN_W'(rcv_count);
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap--;
            end else if (line_ticks.size() != 0) begin
                s_tdata  <= S_TDATA_W'(line_ticks.pop_front());
                s_tvalid <= 1'b1;
                send_gap = pick_gap(src_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink side stalls
    always @(posedge aclk) begin
        if (sink_wait > 0) begin
            m_tready <= 1'b0;
            sink_wait--;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(3) == 0)
                sink_wait = pick_gap(sink_calm);
        end
    end

    always @(posedge aclk) begin : monitor
        rx_result_t got;
        rx_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(rx_result_t)-1:0];
                if (rx_words_due.size() == 0) begin
                    note_mismatch("word with nothing due, m_tdata", 0, m_tdata);
                end else begin
                    want = rx_words_due.pop_front();
                    if (got.byte_valid !== want.byte_valid)
                        note_mismatch("byte_valid", want.byte_valid, got.byte_valid);
                    if (got.rx_data !== want.rx_data)
                        note_mismatch("rx_data", want.rx_data, got.rx_data);
                    if (got.byte_index !== want.byte_index)
                        note_mismatch("byte_index", want.byte_index, got.byte_index);
                    if (got.byte_stored !== want.byte_stored)
                        note_mismatch("byte_stored", want.byte_stored, got.byte_stored);
                    if (got.frame_ready !== want.frame_ready)
                        note_mismatch("frame_ready", want.frame_ready, got.frame_ready);
                    if (got.frame_length !== want.frame_length)
                        note_mismatch("frame_length", want.frame_length, got.frame_length);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_rx_word(line_tick_t'(s_tdata[1:0]), want);
                rx_words_due.push_back(want);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if ($urandom_range(299) == 0)
            src_calm = ~src_calm;
        if ($urandom_range(299) == 0)
            sink_calm = ~sink_calm;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("uart_rx_with_idle_framing_core verification failed");
            $finish;
        end
    end

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [APB_DATA_W-1:0] reg_shadow(input logic [APB_ADDR_W-1:0] addr);
        case (addr)
            ADDR_ENABLE:        return APB_DATA_W'(cfg_enable);
            ADDR_TICKS_PER_BIT: return APB_DATA_W'(cfg_tpb);
            default:            return APB_DATA_W'(cfg_idle_chars);
        endcase
    endfunction

    task automatic check_reg(input logic [APB_ADDR_W-1:0] addr);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, addr, '0, rd);
        if (rd !== reg_shadow(addr))
            note_mismatch("prdata", reg_shadow(addr), rd);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input int unsigned value);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, addr, APB_DATA_W'(value), rd);
        case (addr)
            ADDR_ENABLE:        cfg_enable     = value[0];
            ADDR_TICKS_PER_BIT: cfg_tpb        = TPB_W'(value);
            default:            cfg_idle_chars = IDLE_CHARS_W'(value);
        endcase
        check_reg(addr);
    endtask

    task automatic set_timing(input int unsigned tpb, input int unsigned idle);
        write_reg(ADDR_TICKS_PER_BIT, tpb);
        write_reg(ADDR_IDLE_CHARS, idle);
    endtask

    // wait for the core to empty, then a short pause for the output buffer
    task automatic settle();
        while (line_ticks.size() != 0 || s_tvalid || rx_words_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic void add_tick(input logic level, input logic clr);
        line_tick_t t;
        t.line = level;
        t.clr  = clr | ($urandom_range(999) < clear_permille);
        line_ticks.push_back(t);
        phase_ticks++;
    endfunction

    function automatic void hold_line(input logic level, input int n);
        for (int i = 0; i < n; i++)
            add_tick(level, 1'b0);
    endfunction

    // one 8N1 character at cpb ticks per bit, then gap ticks of idle line
    function automatic void send_char(input logic [7:0] value, input int cpb, input int gap,
                                      input logic stop_level, input bit clr_on_byte);
        int half = (cpb >> 1 == 0) ? 1 : cpb >> 1;
        int hit  = half + 9 * cpb;
        int p;
        logic level;
        for (int i = 0; i < 10 * cpb + gap; i++) begin
            p = i / cpb;
            if (p == 0)
                level = 1'b0;
            else if (p <= 8)
                level = value[p-1];
            else if (p == 9)
                level = stop_level;
            else
                level = 1'b1;
            add_tick(level, clr_on_byte && i == hit);
        end
    endfunction

    initial begin : stimulus
        int cpb;
        int half;
        int roll;
        int thresh;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        check_reg(ADDR_ENABLE);
        check_reg(ADDR_TICKS_PER_BIT);
        check_reg(ADDR_IDLE_CHARS);

        // disabled: every word zero, state held in reset
        add_tick(1'b0, 1'b1);
        add_tick(1'b1, 1'b0);
        add_tick(1'b0, 1'b0);
        add_tick(1'b1, 1'b1);
        settle();

        write_reg(ADDR_ENABLE, 1);
        set_timing(2, 1);
        hold_line(1'b1, 3);
        send_char(8'h00, 2, 2, 1'b1, 1'b0);
        send_char(8'hFF, 2, 0, 1'b1, 1'b0);
        add_tick(1'b0, 1'b0);                    // glitch, start check sees high
        hold_line(1'b1, 2);
        send_char(8'h5A, 2, 0, 1'b0, 1'b0);      // stop bit low, still taken
        hold_line(1'b1, 30);                     // idle long enough for frame_ready
        send_char(8'hA5, 2, 3, 1'b1, 1'b1);      // clear on the byte's own tick
        add_tick(1'b1, 1'b1);
        hold_line(1'b1, 3);
        settle();

        // bit time changed part-way through the start bit
        set_timing(65535, 255);
        hold_line(1'b1, 2);
        hold_line(1'b0, 20);
        settle();
        write_reg(ADDR_TICKS_PER_BIT, 3);
        for (int i = 0; i < 30; i++)
            add_tick(1'($urandom_range(1)), 1'b0);
        hold_line(1'b1, 20);
        hold_line(1'b0, 4);
        settle();
        // disable part-way through a character
        write_reg(ADDR_ENABLE, 0);
        add_tick(1'b0, 1'b0);
        add_tick(1'b1, 1'b1);
        settle();
        write_reg(ADDR_ENABLE, 1);
        hold_line(1'b0, 3);
        hold_line(1'b1, 40);
        settle();

        // a short run of bytes at four ticks per bit, then a clear and one more byte
        set_timing(4, 255);
        for (int i = 0; i < RUN_BYTES; i++)
            send_char(8'($urandom), 4, $urandom_range(3), 1'b1, 1'b0);
        add_tick(1'b1, 1'b1);
        send_char(8'($urandom), 4, 2, 1'b1, 1'b0);
        settle();

        clear_permille = 5;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_timing(rand_tpb[ph], rand_idle[ph]);
            cpb    = (rand_tpb[ph] == 0) ? 1 : rand_tpb[ph];
            half   = (cpb >> 1 == 0) ? 1 : cpb >> 1;
            thresh = cpb * CHAR_BITS * rand_idle[ph];
            phase_ticks = 0;
            hold_line(1'b1, 2);
            while (phase_ticks < PHASE_TICKS) begin
                roll = $urandom_range(99);
                if (roll < 70) begin
                    send_char(8'($urandom), cpb, $urandom_range(2 * cpb), 1'b1,
                              $urandom_range(19) == 0);
                end else if (roll < 78) begin
                    hold_line(1'b0, $urandom_range(half, 1));
                    hold_line(1'b1, $urandom_range(2 * cpb, 1));
                end else if (roll < 85) begin
                    send_char(8'($urandom), cpb, 0, 1'b0, 1'b0);
                    hold_line(1'b1, cpb);
                end else if (roll < 92) begin
                    for (int i = $urandom_range(3 * cpb, 1); i > 0; i--)
                        add_tick(1'($urandom_range(1)), 1'b0);
                    hold_line(1'b1, cpb);
                end else begin
                    hold_line(1'b1, thresh + $urandom_range(2 * cpb, 1));
                end
            end
            settle();
        end

        settle();
        if (fault_count == 0)
            $display("uart_rx_with_idle_framing_core verification clean");
        else
            $display("uart_rx_with_idle_framing_core verification failed");
        $finish;
    end

endmodule
